FILE: hdl/tdch_pkg.sv
`default_nettype none

package tdch_pkg;

	localparam int CH_W        = 12;
	localparam int COARSE_IN_W = 8;
	localparam int FINE_W      = 16;
	localparam int BIN_W       = 16;
	localparam int DIFF_W      = 18;
	localparam int COUNT_W     = 32;
	localparam int FR_W        = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [BIN_W-1:0] BIN_BIAS = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHANNEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CHANNEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_RANGE     = 2'd3;

	typedef enum logic [1:0] {
		KIND_HIT   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_COUNTED  = 3'd0,
		ST_IDLE     = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_SKIPPED  = 3'd3,
		ST_BIN      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_INCR  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} mem_op_t;

	typedef struct packed {
		mem_op_t                  op;
		status_t                  status;
		logic [BIN_W-1:0]         bin;
		logic signed [DIFF_W-1:0] diff;
	} slot_t;

endpackage

`default_nettype wire

FILE: hdl/tdc_channel_difference_histogram_core.sv
`default_nettype none

// TDC channel time-difference histogram. Hits arrive on the slave stream (tuser carries
// the kind, tlast the end of event); the first hit on each of the two configured channels
// is latched, and every completed pair produces a difference that either counts one in a
// saturating 32-bit histogram bin or flags an overflow that skips the rest of the event.
// Read and clear items address single bins. Every item gives exactly one result item.
// The block takes one item per clock while the master side is not stalled: the histogram
// memory is read in the cycle an item is accepted and written back from the stage-one
// register when the pipeline advances, with a one-entry bypass covering back-to-back
// items on the same bin, and the result item is offered from the output register. After
// reset the HIST_BINS bins (65536 by default) are swept to zero, one bin per clock, and
// s_axis_tready stays low during the sweep while configuration writes are still taken.
module tdc_channel_difference_histogram_core #(
	parameter int COARSE_BITS = 8,
	parameter int HIST_BINS   = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// channel [11:0], coarse_time [19:12], fine_time [35:20], bin_index [51:36]
	input  wire logic [55:0] s_axis_tdata,
	// kind [1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// end_of_event
	input  wire logic        s_axis_tlast,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// bin_number [15:0], difference [33:16], bin_count [65:34]
	output logic [71:0]      m_axis_tdata,
	// status [2:0]
	output logic [2:0]       m_axis_tuser
);

	localparam int CW = COARSE_BITS;
	localparam int AW = $clog2(HIST_BINS);
	localparam int DW = tdch_pkg::DIFF_W + 1;

	// Configuration registers
	logic [tdch_pkg::CH_W-1:0] first_channel_q;
	logic [tdch_pkg::CH_W-1:0] second_channel_q;
	logic                      sync_mode_q;
	logic [tdch_pkg::FR_W-1:0] fine_range_q;

	// Event state
	logic                        first_held_q, second_held_q, event_stopped_q;
	logic [CW-1:0]               first_coarse_q, second_coarse_q;
	logic [tdch_pkg::FINE_W-1:0] first_fine_q, second_fine_q;

	logic                        nf_held, ns_held, n_stopped;
	logic [CW-1:0]               nf_coarse, ns_coarse;
	logic [tdch_pkg::FINE_W-1:0] nf_fine, ns_fine;

	// Histogram memory and sweep
	logic [tdch_pkg::COUNT_W-1:0] hist_mem [HIST_BINS];
	logic                         clr_busy_q;
	logic [AW-1:0]                clr_idx_q;
	logic                         mem_we;
	logic [AW-1:0]                mem_wa, rd_addr;
	logic [tdch_pkg::COUNT_W-1:0] mem_wd;
	logic [tdch_pkg::COUNT_W-1:0] rd_s1;

	// Last write, for the bypass
	logic                         wr_vld_q;
	logic [AW-1:0]                wr_addr_q;
	logic [tdch_pkg::COUNT_W-1:0] wr_data_q;

	// Pipeline
	logic            pipe_en, in_accept;
	tdch_pkg::slot_t slot_s0, slot_s1;
	logic            vld_s1;
	logic                         s1_wr;
	logic [tdch_pkg::COUNT_W-1:0] s1_cur, s1_new, s1_count;

	// Output register
	logic                             out_vld_q;
	tdch_pkg::status_t                out_status_q;
	logic [tdch_pkg::BIN_W-1:0]       out_bin_q;
	logic signed [tdch_pkg::DIFF_W-1:0] out_diff_q;
	logic [tdch_pkg::COUNT_W-1:0]     out_count_q;

	// Input fields
	tdch_pkg::kind_t                  in_kind;
	logic [tdch_pkg::CH_W-1:0]        in_channel;
	logic [tdch_pkg::COARSE_IN_W-1:0] in_coarse_raw;
	logic [CW+tdch_pkg::COARSE_IN_W-1:0] in_coarse_ext;
	logic [CW-1:0]                    in_coarse;
	logic [tdch_pkg::FINE_W-1:0]      in_fine;
	logic [tdch_pkg::BIN_W-1:0]       in_bin_index;

	assign in_kind       = tdch_pkg::kind_t'(s_axis_tuser);
	assign in_channel    = s_axis_tdata[11:0];
	assign in_coarse_raw = s_axis_tdata[19:12];
	assign in_fine       = s_axis_tdata[35:20];
	assign in_bin_index  = s_axis_tdata[51:36];
	assign in_coarse_ext = {{CW{1'b0}}, in_coarse_raw};
	assign in_coarse     = in_coarse_ext[CW-1:0];

	assign cfg_ready     = 1'b1;
	assign pipe_en       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = pipe_en && !clr_busy_q;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_channel_q  <= '0;
			second_channel_q <= tdch_pkg::CH_W'(1);
			sync_mode_q      <= 1'b0;
			fine_range_q     <= tdch_pkg::FR_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tdch_pkg::CFG_FIRST_CHANNEL:  first_channel_q  <= cfg_data[11:0];
				tdch_pkg::CFG_SECOND_CHANNEL: second_channel_q <= cfg_data[11:0];
				tdch_pkg::CFG_SYNC_MODE:      sync_mode_q      <= cfg_data[0];
				tdch_pkg::CFG_FINE_RANGE:     fine_range_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Event logic and pair arithmetic for the item being accepted
	always_comb begin
		logic                     pair_go;
		logic                     coarse_eq, coarse_up, coarse_down;
		logic [CW-1:0]            f_inc, s_inc;
		logic signed [DW-1:0]     d_base, d_full;
		logic signed [tdch_pkg::DIFF_W-1:0] d_sat;
		logic                     in_range, overflow;

		nf_held   = first_held_q;
		nf_coarse = first_coarse_q;
		nf_fine   = first_fine_q;
		ns_held   = second_held_q;
		ns_coarse = second_coarse_q;
		ns_fine   = second_fine_q;
		n_stopped = event_stopped_q;
		pair_go   = 1'b0;

		slot_s0.op     = tdch_pkg::OP_NONE;
		slot_s0.status = tdch_pkg::ST_IDLE;
		slot_s0.bin    = '0;
		slot_s0.diff   = '0;

		if (!event_stopped_q) begin
			if (in_channel == first_channel_q) begin
				if (!first_held_q) begin
					nf_held   = 1'b1;
					nf_coarse = in_coarse;
					nf_fine   = in_fine;
					pair_go   = second_held_q;
				end
			end else if (in_channel == second_channel_q && !second_held_q) begin
				ns_held   = 1'b1;
				ns_coarse = in_coarse;
				ns_fine   = in_fine;
				pair_go   = first_held_q;
			end
		end

		f_inc       = nf_coarse + CW'(1);
		s_inc       = ns_coarse + CW'(1);
		coarse_eq   = nf_coarse == ns_coarse;
		coarse_up   = f_inc == ns_coarse;
		coarse_down = s_inc == nf_coarse;

		d_base = $signed({3'b000, ns_fine}) - $signed({3'b000, nf_fine});
		if (sync_mode_q && !coarse_eq && coarse_up) begin
			d_full = d_base + $signed({2'b00, fine_range_q});
		end else if (sync_mode_q && !coarse_eq) begin
			d_full = d_base - $signed({2'b00, fine_range_q});
		end else begin
			d_full = d_base;
		end

		if (sync_mode_q && !coarse_eq && !coarse_up && !coarse_down) begin
			d_sat = '0;
		end else if (d_full > DW'(131071)) begin
			d_sat = 18'sh1FFFF;
		end else if (d_full < -DW'(131072)) begin
			d_sat = 18'sh20000;
		end else begin
			d_sat = d_full[tdch_pkg::DIFF_W-1:0];
		end

		in_range = (d_full >= -DW'(32768)) && (d_full <= DW'(32767));
		overflow = (sync_mode_q && !coarse_eq && !coarse_up && !coarse_down) || !in_range;

		case (in_kind)
			tdch_pkg::KIND_HIT: begin
				if (event_stopped_q) begin
					slot_s0.status = tdch_pkg::ST_SKIPPED;
				end else if (pair_go && overflow) begin
					slot_s0.status = tdch_pkg::ST_OVERFLOW;
					slot_s0.diff   = d_sat;
					n_stopped      = 1'b1;
				end else if (pair_go) begin
					slot_s0.status = tdch_pkg::ST_COUNTED;
					slot_s0.op     = tdch_pkg::OP_INCR;
					slot_s0.diff   = d_sat;
					slot_s0.bin    = d_full[tdch_pkg::BIN_W-1:0] ^ tdch_pkg::BIN_BIAS;
					nf_held        = 1'b0;
					ns_held        = 1'b0;
				end
				if (s_axis_tlast) begin
					nf_held   = 1'b0;
					ns_held   = 1'b0;
					n_stopped = 1'b0;
				end
			end
			tdch_pkg::KIND_READ: begin
				slot_s0.op     = tdch_pkg::OP_READ;
				slot_s0.status = tdch_pkg::ST_BIN;
				slot_s0.bin    = in_bin_index;
			end
			tdch_pkg::KIND_CLEAR: begin
				slot_s0.op     = tdch_pkg::OP_CLEAR;
				slot_s0.status = tdch_pkg::ST_BIN;
				slot_s0.bin    = in_bin_index;
			end
			default: ;
		endcase

		// Non-hit items leave the event state alone
		if (in_kind != tdch_pkg::KIND_HIT) begin
			nf_held   = first_held_q;
			nf_coarse = first_coarse_q;
			nf_fine   = first_fine_q;
			ns_held   = second_held_q;
			ns_coarse = second_coarse_q;
			ns_fine   = second_fine_q;
			n_stopped = event_stopped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_held_q    <= 1'b0;
			second_held_q   <= 1'b0;
			event_stopped_q <= 1'b0;
			first_coarse_q  <= '0;
			second_coarse_q <= '0;
			first_fine_q    <= '0;
			second_fine_q   <= '0;
		end else if (in_accept) begin
			first_held_q    <= nf_held;
			second_held_q   <= ns_held;
			event_stopped_q <= n_stopped;
			first_coarse_q  <= nf_coarse;
			second_coarse_q <= ns_coarse;
			first_fine_q    <= nf_fine;
			second_fine_q   <= ns_fine;
		end
	end

	assign rd_addr = AW'(slot_s0.bin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			slot_s1 <= slot_s0;
		end
	end

	// A write made in the same cycle as this item's read is not yet in the read data
	assign s1_cur = (wr_vld_q && wr_addr_q == AW'(slot_s1.bin)) ? wr_data_q : rd_s1;
	assign s1_new = (s1_cur == '1) ? s1_cur : s1_cur + tdch_pkg::COUNT_W'(1);

	always_comb begin
		s1_wr    = 1'b0;
		s1_count = '0;
		case (slot_s1.op)
			tdch_pkg::OP_INCR: begin
				s1_wr    = 1'b1;
				s1_count = s1_new;
			end
			tdch_pkg::OP_READ: begin
				s1_count = s1_cur;
			end
			tdch_pkg::OP_CLEAR: begin
				s1_wr    = 1'b1;
				s1_count = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else begin
			mem_we = vld_s1 && s1_wr && pipe_en;
			mem_wa = AW'(slot_s1.bin);
			mem_wd = s1_count;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_wa] <= mem_wd;
		end
		if (pipe_en) begin
			rd_s1 <= hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(HIST_BINS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (pipe_en) begin
			wr_vld_q <= vld_s1 && s1_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			wr_addr_q <= AW'(slot_s1.bin);
			wr_data_q <= s1_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pipe_en) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_status_q <= slot_s1.status;
			out_bin_q    <= slot_s1.bin;
			out_diff_q   <= slot_s1.diff;
			out_count_q  <= s1_count;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {6'b000000, out_count_q, out_diff_q, out_bin_q};

	// A counted bin sits at the biased difference.
	a_counted_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_status_q == tdch_pkg::ST_COUNTED)
			|-> (out_bin_q == (out_diff_q[tdch_pkg::BIN_W-1:0] ^ tdch_pkg::BIN_BIAS)))
		else $error("counted bin does not match difference");

	// Both latches held at once only after an overflow stopped the event.
	a_pair_resolved: assert property (@(posedge clk) disable iff (!arst_n)
		(first_held_q && second_held_q) |-> event_stopped_q)
		else $error("pair held without being resolved");

	// Nothing moves through the pipeline while the histogram is being swept.
	a_sweep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!vld_s1 && !out_vld_q && !s_axis_tready))
		else $error("item in flight during histogram sweep");

	// A counted item raises its bin by at most one over what was stored.
	a_incr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && pipe_en && slot_s1.op == tdch_pkg::OP_INCR)
			|-> (s1_count == s1_cur || s1_count == s1_cur + tdch_pkg::COUNT_W'(1)))
		else $error("bin increment out of step");

endmodule

`default_nettype wire

FILE: test/tdch_histogram_checker.sv
module tdch_histogram_checker
	import tdch_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,

	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [55:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        s_axis_tlast,

	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [71:0] m_axis_tdata,
	input  wire logic [2:0]  m_axis_tuser,

	output int               fail_count,
	output int               outstanding,
	output int               pairs_counted,
	output int               overflows,
	output int               skipped_hits
);

	localparam int COARSE_BITS = 8;
	localparam int COARSE_MASK = (1 << COARSE_BITS) - 1;
	localparam int HIST_DEPTH  = 1 << BIN_W;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		status_t                  status;
		logic [BIN_W-1:0]         bin;
		logic signed [DIFF_W-1:0] diff;
		logic [COUNT_W-1:0]       count;
	} outcome_t;

	logic [COUNT_W-1:0] hist [0:HIST_DEPTH-1];

	logic [CH_W-1:0] first_ch;
	logic [CH_W-1:0] second_ch;
	logic            sync_on;
	logic [FR_W-1:0] fine_range;

	logic start_held;
	logic stop_held;
	logic event_stopped;
	int   start_coarse;
	int   start_fine;
	int   stop_coarse;
	int   stop_fine;

	outcome_t outcome_q [$];
	int       n_fail;
	int       n_results;
	int       n_counted;
	int       n_overflow;
	int       n_skipped;

	// Both latches are full: form second minus first and count it if it fits.
	function automatic outcome_t close_pair();
		outcome_t r;
		int       d;
		bit       up;
		bit       down;
		r.status = ST_OVERFLOW;
		r.bin    = '0;
		r.diff   = '0;
		r.count  = '0;
		d = stop_fine - start_fine;
		if (sync_on) begin
			up   = ((start_coarse + 1) & COARSE_MASK) == stop_coarse;
			down = ((stop_coarse + 1) & COARSE_MASK) == start_coarse;
			if (start_coarse != stop_coarse && !up && !down)
				return r;
			if (start_coarse != stop_coarse)
				d = up ? d + int'(fine_range) : d - int'(fine_range);
		end
		if (d < -32768 || d > 32767) begin
			if (d > 131071)
				d = 131071;
			if (d < -131072)
				d = -131072;
			r.diff = d[DIFF_W-1:0];
			return r;
		end
		r.bin = BIN_W'(d + 32768);
		if (hist[r.bin] != '1)
			hist[r.bin] = hist[r.bin] + 1;
		r.status   = ST_COUNTED;
		r.diff     = d[DIFF_W-1:0];
		r.count    = hist[r.bin];
		start_held = 1'b0;
		stop_held  = 1'b0;
		return r;
	endfunction

	function automatic outcome_t histogram_step(kind_t kind, logic [CH_W-1:0] ch,
			logic [COARSE_IN_W-1:0] coarse, logic [FINE_W-1:0] fine, logic eoe,
			logic [BIN_W-1:0] bin_idx);
		outcome_t r;
		r.status = ST_IDLE;
		r.bin    = '0;
		r.diff   = '0;
		r.count  = '0;
		case (kind)
			KIND_READ: begin
				r.status = ST_BIN;
				r.bin    = bin_idx;
				r.count  = hist[bin_idx];
				return r;
			end
			KIND_CLEAR: begin
				hist[bin_idx] = '0;
				r.status      = ST_BIN;
				r.bin         = bin_idx;
				return r;
			end
			KIND_NONE: begin
				return r;
			end
			default: ;
		endcase
		if (event_stopped) begin
			r.status = ST_SKIPPED;
		end else if (ch == first_ch) begin
			if (!start_held) begin
				start_held   = 1'b1;
				start_coarse = int'(coarse) & COARSE_MASK;
				start_fine   = int'(fine);
				if (stop_held)
					r = close_pair();
			end
		end else if (ch == second_ch && !stop_held) begin
			stop_held   = 1'b1;
			stop_coarse = int'(coarse) & COARSE_MASK;
			stop_fine   = int'(fine);
			if (start_held)
				r = close_pair();
		end
		if (r.status == ST_OVERFLOW)
			event_stopped = 1'b1;
		if (eoe) begin
			start_held    = 1'b0;
			stop_held     = 1'b0;
			event_stopped = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++)
				hist[i] = '0;
			first_ch      = 12'd0;
			second_ch     = 12'd1;
			sync_on       = 1'b0;
			fine_range    = 17'd65536;
			start_held    = 1'b0;
			stop_held     = 1'b0;
			event_stopped = 1'b0;
			start_coarse  = 0;
			start_fine    = 0;
			stop_coarse   = 0;
			stop_fine     = 0;
			outcome_q.delete();
			n_fail     = 0;
			n_results  = 0;
			n_counted  = 0;
			n_overflow = 0;
			n_skipped  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_CHANNEL:  first_ch   = cfg_data[CH_W-1:0];
					CFG_SECOND_CHANNEL: second_ch  = cfg_data[CH_W-1:0];
					CFG_SYNC_MODE:      sync_on    = cfg_data[0];
					CFG_FINE_RANGE:     fine_range = cfg_data[FR_W-1:0];
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.bin    = m_axis_tdata[15:0];
				got.diff   = m_axis_tdata[33:16];
				got.count  = m_axis_tdata[65:34];
				n_results++;
				if (outcome_q.size() == 0) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("result %0d arrived with nothing pending: status %0d bin %0d",
							n_results, got.status, got.bin);
				end else begin
					want = outcome_q.pop_front();
					if (got.status != want.status || got.bin != want.bin ||
							got.diff != want.diff || got.count != want.count) begin
						n_fail++;
						if (n_fail <= MAX_REPORTS)
							$display({"result %0d mismatch: expected status %0d bin %0d diff %0d ",
								"count %0d, got status %0d bin %0d diff %0d count %0d"},
								n_results, want.status, want.bin, want.diff, want.count,
								got.status, got.bin, got.diff, got.count);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				want = histogram_step(kind_t'(s_axis_tuser), s_axis_tdata[11:0],
					s_axis_tdata[19:12], s_axis_tdata[35:20], s_axis_tlast,
					s_axis_tdata[51:36]);
				case (want.status)
					ST_COUNTED:  n_counted++;
					ST_OVERFLOW: n_overflow++;
					ST_SKIPPED:  n_skipped++;
					default: ;
				endcase
				outcome_q.push_back(want);
			end
		end
		fail_count    <= n_fail;
		outstanding   <= outcome_q.size();
		pairs_counted <= n_counted;
		overflows     <= n_overflow;
		skipped_hits  <= n_skipped;
	end

endmodule

FILE: test/testbench.sv
module testbench;
	import tdch_pkg::*;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [16:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	int fail_count;
	int outstanding;
	int pairs_counted;
	int overflows;
	int skipped_hits;

	logic [CH_W-1:0] cur_first;
	logic [CH_W-1:0] cur_second;

	int burst_left = 0;
	int items_sent = 0;
	int stall_left = 0;
	int rx_cycle   = 0;

	tdc_channel_difference_histogram_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	tdch_histogram_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.pairs_counted (pairs_counted),
		.overflows     (overflows),
		.skipped_hits  (skipped_hits)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver runs freely for one stretch in four and stalls at random otherwise.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_cycle[8:7] != 2'd0 && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
		rx_cycle++;
	end

	initial begin
		#1000000;
		$display("testbench: done, errors");
		$finish;
	end

	// Called at a falling edge and returns at one. The valid line only drops for a gap
	// between bursts, so an item that follows directly keeps it high.
	task automatic send_item(input kind_t kind, input logic [CH_W-1:0] ch,
			input logic [COARSE_IN_W-1:0] coarse, input logic [FINE_W-1:0] fine,
			input logic eoe, input logic [BIN_W-1:0] bin_idx);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tlast  <= eoe;
		s_axis_tdata  <= {4'b0000, bin_idx, fine, coarse, ch};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic hit(input logic [CH_W-1:0] ch, input logic [COARSE_IN_W-1:0] coarse,
			input logic [FINE_W-1:0] fine, input logic eoe);
		send_item(KIND_HIT, ch, coarse, fine, eoe, '0);
	endtask

	task automatic bin_access(input kind_t kind, input logic [BIN_W-1:0] bin_idx);
		send_item(kind, '0, '0, '0, 1'b0, bin_idx);
	endtask

	// Writes all four registers back to back, holding valid high between them.
	task automatic configure(input logic [CH_W-1:0] first, input logic [CH_W-1:0] second,
			input logic sync, input logic [FR_W-1:0] range);
		logic [CFG_IDX_W-1:0]  regs [4];
		logic [CFG_DATA_W-1:0] vals [4];
		regs = '{CFG_FIRST_CHANNEL, CFG_SECOND_CHANNEL, CFG_SYNC_MODE, CFG_FINE_RANGE};
		vals = '{17'(first), 17'(second), 17'(sync), range};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid  <= 1'b0;
		cur_first  = first;
		cur_second = second;
	endtask

	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One event: hits around a common coarse and fine base so that pairs mostly count,
	// with stray channels, bin reads and clears mixed in. Now and then the event is
	// left open and runs on into the next one.
	task automatic random_event();
		int                     n;
		int                     pick;
		bit                     broken;
		logic [COARSE_IN_W-1:0] c0;
		logic [COARSE_IN_W-1:0] c;
		logic [FINE_W-1:0]      f0;
		logic [FINE_W-1:0]      f;
		logic [CH_W-1:0]        ch;
		logic [BIN_W-1:0]       idx;
		logic                   eoe;
		kind_t                  kind;
		n      = $urandom_range(1, 6);
		broken = ($urandom_range(0, 9) == 0);
		c0     = 8'($urandom);
		if ($urandom_range(0, 2) == 0)
			f0 = 16'($urandom);
		else
			f0 = 16'd20000 + 16'($urandom_range(0, 3));
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick >= 90) begin
				if (pick < 96)
					kind = KIND_READ;
				else if (pick < 98)
					kind = KIND_CLEAR;
				else
					kind = KIND_NONE;
				if ($urandom_range(0, 1) == 0)
					idx = 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
				else
					idx = 16'($urandom);
				send_item(kind, 12'($urandom), 8'($urandom), 16'($urandom),
					1'($urandom), idx);
				if (kind != KIND_NONE)
					items_sent++;
			end else begin
				if (pick < 40)
					ch = cur_first;
				else if (pick < 80)
					ch = cur_second;
				else
					ch = 12'($urandom);
				if ($urandom_range(0, 9) == 0)
					c = 8'($urandom);
				else
					c = c0 + 8'($urandom_range(0, 2)) - 8'd1;
				if ($urandom_range(0, 9) == 0)
					f = 16'($urandom);
				else
					f = f0 + 16'($urandom_range(0, 7));
				if (i == n - 1)
					eoe = !broken;
				else
					eoe = ($urandom_range(0, 19) == 0);
				send_item(KIND_HIT, ch, c, f, eoe, 16'($urandom));
				if (pick < 80)
					items_sent++;
			end
		end
	endtask

	initial begin
		logic [CH_W-1:0] ch_a;
		int              target;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fine-only differences, including both ends of the counted range and overflows.
		configure(12'd5, 12'd9, 1'b0, 17'd65536);
		bin_access(KIND_READ, 16'h0000);
		bin_access(KIND_READ, 16'hFFFF);
		hit(12'd9, 8'd0, 16'd100, 1'b0);
		hit(12'd5, 8'd0, 16'd50, 1'b0);
		hit(12'd5, 8'd0, 16'd0, 1'b0);
		hit(12'd5, 8'd0, 16'd7, 1'b0);
		hit(12'd9, 8'd0, 16'hFFFF, 1'b0);
		hit(12'd5, 8'd0, 16'd3, 1'b1);
		hit(12'd5, 8'd0, 16'h8000, 1'b0);
		hit(12'd9, 8'd0, 16'd0, 1'b0);
		hit(12'd5, 8'd0, 16'd0, 1'b0);
		hit(12'd9, 8'd0, 16'h7FFF, 1'b1);
		send_item(KIND_NONE, 12'hFFF, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF);
		bin_access(KIND_CLEAR, 16'hFFFF);
		bin_access(KIND_READ, 16'hFFFF);
		quiesce();

		// Both registers name the same channel, so no pair can form.
		configure(12'd7, 12'd7, 1'b0, 17'd65536);
		hit(12'd7, 8'd0, 16'd10, 1'b0);
		hit(12'd7, 8'd0, 16'd20, 1'b1);
		quiesce();

		// Coarse unwrapping: equal stamps, a step up across the wrap, a step down,
		// and stamps too far apart.
		configure(12'd4095, 12'd0, 1'b1, 17'd1000);
		hit(12'd4095, 8'd10, 16'd500, 1'b0);
		hit(12'd0, 8'd10, 16'd700, 1'b0);
		hit(12'd4095, 8'd255, 16'd900, 1'b0);
		hit(12'd0, 8'd0, 16'd100, 1'b0);
		hit(12'd4095, 8'd0, 16'd100, 1'b0);
		hit(12'd0, 8'd255, 16'd900, 1'b0);
		hit(12'd0, 8'd5, 16'd1, 1'b0);
		hit(12'd4095, 8'd9, 16'd2, 1'b1);
		bin_access(KIND_READ, 16'h8000 + 16'd200);
		quiesce();

		for (int ph = 0; ph < 6; ph++) begin
			ch_a = 12'($urandom);
			case (ph)
				0: configure(ch_a, ch_a + 12'($urandom_range(1, 4095)), 1'b0, 17'd65536);
				1: configure(ch_a, ch_a + 12'($urandom_range(1, 4095)), 1'b1, 17'd65536);
				2: configure(ch_a, ch_a + 12'($urandom_range(1, 4095)), 1'b1, 17'd0);
				3: configure(ch_a, ch_a + 12'($urandom_range(1, 4095)), 1'b1,
					17'($urandom_range(1, 4000)));
				4: configure(ch_a, ch_a, 1'($urandom), 17'($urandom_range(0, 65536)));
				default: configure(12'd4095, 12'd0, 1'b1, 17'h1FFFF);
			endcase
			target = items_sent + 100;
			while (items_sent < target)
				random_event();
			quiesce();
		end

		$display("run covered %0d random items over six register settings",
			items_sent);
		$display("pairs counted %0d, overflows %0d, hits skipped after overflow %0d",
			pairs_counted, overflows, skipped_hits);
		if (fail_count == 0 && outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: files.f
hdl/tdch_pkg.sv
hdl/tdc_channel_difference_histogram_core.sv
test/tdch_histogram_checker.sv
test/testbench.sv
